/* hdl/fea_pkg.sv */
// Package for the free extent allocator.
// Opcodes, status codes, sequencer states, result record and defaults.
// No dependencies.
package fea_pkg;

  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_OFFSET_BITS = 32;
  localparam logic [31:0] POOL_RESET = 32'd65536;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CLEAR
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_FIT,
    ST_DOUBLE,
    ST_ZERO,
    ST_FULL,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic [3:0] {
    S_BUILD,
    S_IDLE,
    S_AWALK,
    S_FWALK,
    S_BRIDGE,
    S_SCAN,
    S_APPLY,
    S_W2,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_HEAD,
    M_TAIL,
    M_INS
  } mode_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] granted;
    logic [31:0] free_bytes;
  } res_t;

endpackage

/* hdl/fea_if.sv */
// Channel interfaces of the free extent allocator: request, response, config.
// Each carries valid, ready and payload; no package dependency.
interface fea_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] block_size;
  logic [31:0] block_start;
  modport source (output valid, opcode, block_size, block_start, input ready);
  modport sink (input valid, opcode, block_size, block_start, output ready);
endinterface

interface fea_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] granted_offset;
  logic [31:0] free_bytes;
  modport source (output valid, status, granted_offset, free_bytes, input ready);
  modport sink (input valid, status, granted_offset, free_bytes, output ready);
endinterface

interface fea_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] pool_size;
  modport source (output valid, pool_size, input ready);
  modport sink (input valid, pool_size, output ready);
endinterface

/* hdl/fea_table.sv */
// Extent table memory: one write port, one read port with registered data.
// Entry = {offset, length, link}. No package dependency.
module fea_table #(
  parameter int MAX_EXTENTS = 64,
  parameter int EW = 71
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(MAX_EXTENTS)-1:0] waddr,
  input  logic [EW-1:0]                  wdata,
  input  logic [$clog2(MAX_EXTENTS)-1:0] raddr,
  output logic [EW-1:0]                  rdata
);

  logic [EW-1:0] mem [MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fea_seq.sv */
// Sequencer of the free extent allocator: walks the sorted extent list one
// entry per cycle, scans the in-use map for a free slot, updates the table.
// Uses fea_pkg; drives the ports of fea_table.
module fea_seq #(
  parameter int MAX_EXTENTS = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            go,
  input  logic [1:0]                                      in_op,
  input  logic [OFFSET_BITS-1:0]                          in_size,
  input  logic [OFFSET_BITS-1:0]                          in_start,
  input  logic                                            rebuild,
  input  logic [OFFSET_BITS-1:0]                          pool,
  input  logic                                            out_free,
  output logic                                            idle,
  output logic                                            res_valid,
  output fea_pkg::res_t                                   res,
  output logic                                            mem_we,
  output logic [$clog2(MAX_EXTENTS)-1:0]                  mem_waddr,
  output logic [2*OFFSET_BITS+$clog2(MAX_EXTENTS+1)-1:0]  mem_wdata,
  output logic [$clog2(MAX_EXTENTS)-1:0]                  mem_raddr,
  input  logic [2*OFFSET_BITS+$clog2(MAX_EXTENTS+1)-1:0]  mem_rdata
);
  import fea_pkg::*;

  localparam int W  = OFFSET_BITS;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int LW = $clog2(MAX_EXTENTS + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_EXTENTS);
  localparam logic [IW-1:0] LAST = IW'(MAX_EXTENTS - 1);

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    return (a > ('1 - b)) ? '1 : a + b;
  endfunction

  state_t state, state_next;
  mode_t  mode;
  logic [W-1:0] size, bstart, granted, total;
  logic [LW-1:0] head, cur, prev, cur_link;
  logic [W-1:0] cur_off, cur_len, prev_off, prev_len;
  logic [IW-1:0] steps, scan_idx, slot, pend_addr;
  logic [2*W+LW-1:0] pend_data;
  logic [MAX_EXTENTS-1:0] used;
  logic build_op;
  status_t status;

  logic [W-1:0] rd_off, rd_len, t_off, t_len, s_len, total_add, total_sub;
  logic [LW-1:0] rd_link, s_link;
  logic [W:0] rd_end, end_w;
  logic head_ok, prev_ok, link_ok, walk_more, in_zero, in_range;
  logic a_exact, a_big, off_end, f_touch, f_dbl, f_ins, f_tail, b_join;
  logic i_mnext, i_mprev, scan_hit, scan_last;

  assign rd_off  = mem_rdata[2*W+LW-1 -: W];
  assign rd_len  = mem_rdata[W+LW-1 -: W];
  assign rd_link = mem_rdata[LW-1:0];
  assign rd_end  = {1'b0, rd_off} + {1'b0, rd_len};
  assign end_w   = {1'b0, bstart} + {1'b0, size};

  assign head_ok   = head < NIL;
  assign prev_ok   = prev < NIL;
  assign link_ok   = rd_link < NIL;
  assign walk_more = link_ok && (steps != LAST);
  assign in_zero   = in_size == '0;
  assign in_range  = (in_start > pool) || (in_size > pool - in_start);

  assign a_exact = rd_len == size;
  assign a_big   = rd_len > size;
  assign off_end = {1'b0, rd_off} == end_w;
  assign f_touch = (rd_end == {1'b0, bstart}) || off_end;
  assign f_dbl   = rd_off == bstart;
  assign f_ins   = rd_off > bstart;
  assign f_tail  = !link_ok && (rd_end < {1'b0, bstart});
  assign t_off   = off_end ? bstart : rd_off;
  assign t_len   = rd_len + size;
  assign b_join  = {1'b0, rd_off} == ({1'b0, cur_off} + {1'b0, cur_len});

  assign i_mnext = end_w == {1'b0, cur_off};
  assign s_len   = i_mnext ? size + cur_len : size;
  assign s_link  = i_mnext ? cur_link : cur;
  assign i_mprev = prev_ok && (({1'b0, prev_off} + {1'b0, prev_len}) == {1'b0, bstart});

  assign scan_hit  = !used[scan_idx];
  assign scan_last = scan_idx == LAST;

  assign total_add = sat_add(total, size);
  assign total_sub = (total > size) ? total - size : '0;

  assign idle            = state == S_IDLE;
  assign res_valid       = (state == S_DONE) && out_free;
  assign res.status      = status;
  assign res.granted     = 32'(granted);
  assign res.free_bytes  = 32'(total);

  always_comb begin
    state_next = state;
    unique case (state)
      S_BUILD: state_next = build_op ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (go) begin
          unique case (in_op)
            OP_ALLOC: state_next = (in_zero || !head_ok) ? S_DONE : S_AWALK;
            OP_FREE: begin
              if (in_zero || in_range) state_next = S_DONE;
              else if (!head_ok) state_next = S_SCAN;
              else state_next = S_FWALK;
            end
            OP_CLEAR: state_next = S_BUILD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_AWALK: state_next = (a_exact || a_big || !walk_more) ? S_DONE : S_AWALK;
      S_FWALK: begin
        if (f_touch) state_next = link_ok ? S_BRIDGE : S_DONE;
        else if (f_dbl) state_next = S_DONE;
        else if (f_ins || f_tail) state_next = S_SCAN;
        else state_next = walk_more ? S_FWALK : S_DONE;
      end
      S_BRIDGE: state_next = S_DONE;
      S_SCAN: begin
        if (scan_hit) state_next = S_APPLY;
        else if (scan_last) state_next = S_DONE;
      end
      S_APPLY: begin
        if (mode == M_TAIL || (mode == M_INS && !i_mprev && prev_ok)) state_next = S_W2;
        else state_next = S_DONE;
      end
      S_W2: state_next = S_DONE;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
    if (rebuild) state_next = S_BUILD;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur[IW-1:0];
    mem_wdata = '0;
    mem_raddr = rd_link[IW-1:0];
    unique case (state)
      S_BUILD: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {{W{1'b0}}, pool, NIL};
      end
      S_IDLE: mem_raddr = head[IW-1:0];
      S_AWALK: begin
        if (a_exact) begin
          mem_we    = prev_ok;
          mem_waddr = prev[IW-1:0];
          mem_wdata = {prev_off, prev_len, rd_link};
        end else if (a_big) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_off + size, rd_len - size, rd_link};
        end
      end
      S_FWALK: begin
        mem_we    = f_touch && !link_ok;
        mem_wdata = {t_off, t_len, rd_link};
      end
      S_BRIDGE: begin
        mem_we    = 1'b1;
        mem_wdata = b_join ? {cur_off, cur_len + rd_len, rd_link} : {cur_off, cur_len, cur_link};
      end
      S_APPLY: begin
        mem_we = 1'b1;
        if (mode != M_INS) begin
          mem_waddr = slot;
          mem_wdata = {bstart, size, NIL};
        end else if (i_mprev) begin
          mem_waddr = prev[IW-1:0];
          mem_wdata = {prev_off, prev_len + s_len, s_link};
        end else begin
          mem_waddr = slot;
          mem_wdata = {bstart, s_len, s_link};
        end
      end
      S_W2: begin
        mem_we    = 1'b1;
        mem_waddr = pend_addr;
        mem_wdata = pend_data;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_BUILD;
      build_op <= 1'b0;
      used     <= '0;
      head     <= NIL;
      total    <= '0;
      status   <= ST_OK;
      granted  <= '0;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      if (state != S_SCAN) scan_idx <= '0;
      unique case (state)
        S_BUILD: begin
          used     <= MAX_EXTENTS'(pool != '0);
          head     <= (pool != '0) ? '0 : NIL;
          total    <= pool;
          status   <= ST_OK;
          granted  <= '0;
          build_op <= 1'b0;
        end
        S_IDLE: begin
          if (go) begin
            size    <= in_size;
            bstart  <= in_start;
            granted <= '0;
            cur     <= head;
            prev    <= NIL;
            steps   <= '0;
            mode    <= M_HEAD;
            unique case (in_op)
              OP_ALLOC: begin
                if (in_zero) status <= ST_ZERO;
                else if (!head_ok) status <= ST_NO_FIT;
                else status <= ST_OK;
              end
              OP_FREE: begin
                if (in_zero) status <= ST_ZERO;
                else if (in_range) status <= ST_NOT_FOUND;
                else status <= ST_OK;
              end
              OP_CLEAR: begin
                status   <= ST_OK;
                build_op <= !rebuild;
              end
              default: status <= ST_OK;
            endcase
          end
        end
        S_AWALK: begin
          if (a_exact || a_big) begin
            granted <= rd_off;
            total   <= total_sub;
            if (a_exact) begin
              used[cur[IW-1:0]] <= 1'b0;
              if (!prev_ok) head <= rd_link;
            end
          end else begin
            prev      <= cur;
            prev_off  <= rd_off;
            prev_len  <= rd_len;
            cur       <= rd_link;
            steps     <= steps + 1'b1;
            if (!walk_more) status <= ST_NO_FIT;
          end
        end
        S_FWALK: begin
          if (f_touch) begin
            cur_off  <= t_off;
            cur_len  <= t_len;
            cur_link <= rd_link;
            if (!link_ok) total <= total_add;
          end else if (f_dbl) begin
            status <= ST_DOUBLE;
          end else if (f_ins || f_tail) begin
            cur_off  <= rd_off;
            cur_len  <= rd_len;
            cur_link <= rd_link;
            mode     <= f_ins ? M_INS : M_TAIL;
          end else begin
            prev      <= cur;
            prev_off  <= rd_off;
            prev_len  <= rd_len;
            cur       <= rd_link;
            steps     <= steps + 1'b1;
            if (!walk_more) status <= ST_NOT_FOUND;
          end
        end
        S_BRIDGE: begin
          if (b_join) used[cur_link[IW-1:0]] <= 1'b0;
          total <= total_add;
        end
        S_SCAN: begin
          slot <= scan_idx;
          if (!scan_hit) begin
            scan_idx <= scan_idx + 1'b1;
            if (scan_last) status <= ST_FULL;
          end
        end
        S_APPLY: begin
          total <= total_add;
          unique case (mode)
            M_HEAD: begin
              used[slot] <= 1'b1;
              head       <= LW'(slot);
            end
            M_TAIL: begin
              used[slot] <= 1'b1;
              pend_addr  <= cur[IW-1:0];
              pend_data  <= {cur_off, cur_len, LW'(slot)};
            end
            M_INS: begin
              if (i_mnext) used[cur[IW-1:0]] <= 1'b0;
              if (!i_mprev) begin
                used[slot] <= 1'b1;
                if (prev_ok) begin
                  pend_addr <= prev[IW-1:0];
                  pend_data <= {prev_off, prev_len, LW'(slot)};
                end else begin
                  head <= LW'(slot);
                end
              end
            end
            default: head <= head;
          endcase
        end
        default: status <= status;
      endcase
    end
  end

endmodule

/* hdl/free_extent_allocator.sv */
// Free extent allocator: first-fit allocate, coalescing free and clear over a
// sorted free list of up to MAX_EXTENTS extents.
// Channels: req (opcode, block_size, block_start), rsp (status,
// granted_offset, free_bytes), cfg (pool_size). A transfer happens at a
// rising edge with valid and ready both high. cfg.ready is always high;
// a pool_size write rebuilds the table as a clear does.
// One request is in flight at a time; req.ready drops after a transfer.
// Allocate walks the list from the head, one table read per cycle, over up to
// MAX_EXTENTS extents. Free walks the same way, and bridges to the next extent
// when the freed range touches one that has a successor; when a new extent
// is needed, it scans the in-use map for the lowest free entry, one entry per
// cycle, then writes the table in S_APPLY and, for a new link, in S_W2. Clear
// rebuilds the table in S_BUILD; zero size and rejected requests go straight
// to S_DONE; req.ready rises with rsp.valid.
// The response sits in an output register; a stalled rsp holds it and the
// next request is still taken, finishing only once the register frees.
// After rst (synchronous) the table is built for a 65536-byte pool
// in S_BUILD before req.ready rises.
module free_extent_allocator #(
  parameter int MAX_EXTENTS = fea_pkg::DEF_MAX_EXTENTS,
  parameter int OFFSET_BITS = fea_pkg::DEF_OFFSET_BITS
) (
  input logic      clk,
  input logic      rst,
  fea_req_if.sink  req,
  fea_rsp_if.source rsp,
  fea_cfg_if.sink  cfg
);
  import fea_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int EW = 2 * OFFSET_BITS + $clog2(MAX_EXTENTS + 1);

  logic [31:0] pool_reg;
  logic idle, res_valid, out_free, mem_we;
  res_t res;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic rsp_valid;
  res_t rsp_data;
  logic go;

  assign cfg.ready = 1'b1;
  assign req.ready = idle;
  assign go        = req.valid && idle;
  assign out_free  = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_reg  <= POOL_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) pool_reg <= cfg.pool_size;
      if (res_valid) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) rsp_data <= res;
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_data.status;
  assign rsp.granted_offset = rsp_data.granted;
  assign rsp.free_bytes     = rsp_data.free_bytes;

  fea_seq #(
    .MAX_EXTENTS(MAX_EXTENTS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .in_op    (req.opcode),
    .in_size  (OFFSET_BITS'(req.block_size)),
    .in_start (OFFSET_BITS'(req.block_start)),
    .rebuild  (cfg.valid),
    .pool     (OFFSET_BITS'(pool_reg)),
    .out_free (out_free),
    .idle     (idle),
    .res_valid(res_valid),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fea_table #(
    .MAX_EXTENTS(MAX_EXTENTS),
    .EW(EW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while one is in flight");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |=> !req.ready)
    else $error("request taken during table rebuild");

  a_grant_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> rsp.granted_offset == 32'd0)
    else $error("offset granted on failed operation");

endmodule
